### hw/rtl/prqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prqs_pkg;

	localparam int PRIO_LEVELS = 32;
	localparam int MAX_TASKS   = 64;

	localparam int LVL_W  = $clog2(PRIO_LEVELS);
	localparam int TASK_W = $clog2(MAX_TASKS);

	// priority search: groups of eight levels
	localparam int GRP_W  = 3;
	localparam int GRP    = 1 << GRP_W;
	localparam int NGRP   = PRIO_LEVELS / GRP;
	localparam int NGRP_W = LVL_W - GRP_W;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;

	typedef logic [LVL_W-1:0]       lvl_t;
	typedef logic [TASK_W-1:0]      task_t;
	typedef logic [PRIO_LEVELS-1:0] bitmap_t;

	typedef enum logic [1:0] {
		CMD_READY   = 2'd0,
		CMD_UNREADY = 2'd1,
		CMD_SCHED_P = 2'd2,
		CMD_SCHED_N = 2'd3
	} cmd_t;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_EMPTY   = 2'd1;
	localparam logic [1:0] STAT_REFUSED = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/priority_ready_queue_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser: cmd; tdata: request fields
// m_axis    out  m_axis_tvalid / m_axis_tready   tuser: status; tdata: next_task, switch_req
//
// One command at a time: after an accept the command steps through its states and
// the result register loads in S_FIN on the same edge that returns the block to
// idle, where the input is ready again. The steps are set by the single-ported link,
// level and head/tail memories, each with a registered read.
// Reset clears the level bitmap and the per-task queued bits; memories need no clearing.
// A finished result waits in the output register while the next command is taken.

module priority_ready_queue_scheduler (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [5:0] task_req, [10:6] prio, [16:11] cur_task, [21:17] cur_prio,
	// [22] in_isr, [23] sched_locked
	input  wire logic [prqs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] cmd
	input  wire logic [1:0]                      s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// [5:0] next_task, [6] switch_req, [7] zero
	output logic [prqs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// [1:0] status
	output logic [1:0]                           m_axis_tuser
);
	import prqs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_R2,
		S_U2,
		S_U3,
		S_S2,
		S_S3,
		S_FIN
	} state_t;

	state_t state_q;

	cmd_t  cmd_q;
	task_t task_q, cur_q;
	lvl_t  prio_q, cprio_q;
	logic  isr_q, lock_q;

	bitmap_t              ready_q;
	logic [MAX_TASKS-1:0] queued_q;

	lvl_t  best, best_q, lv_q;
	task_t n_q, p_q, h_q, t_q;
	task_t res_next_q;
	logic [1:0] res_stat_q;

	logic       m_valid_q, m_sw_q;
	task_t      m_next_q;
	logic [1:0] m_stat_q;

	// memories
	task_t nxt_mem [MAX_TASKS];
	task_t prv_mem [MAX_TASKS];
	lvl_t  lvl_mem [MAX_TASKS];
	task_t head_mem [PRIO_LEVELS];
	task_t tail_mem [PRIO_LEVELS];

	task_t nxt_rd, prv_rd, head_rd, tail_rd;
	lvl_t  lvl_rd;

	logic  nxt_we, prv_we, lvl_we, head_we, tail_we;
	task_t nxt_a, prv_a, lvl_a;
	lvl_t  head_a, tail_a;
	task_t nxt_wd, prv_wd, head_wd, tail_wd;
	lvl_t  lvl_wd;

	logic task_ok, prio_ok, refuse, is_head, is_tail;

	prqs_ffs u_ffs (
		.clk    (clk),
		.arst_n (arst_n),
		.bits   (ready_q),
		.best   (best)
	);

	assign task_ok = int'(task_q) < MAX_TASKS;
	assign prio_ok = int'(prio_q) < PRIO_LEVELS;
	assign refuse  = isr_q || lock_q;
	assign is_head = head_rd == task_q;
	assign is_tail = tail_rd == task_q;

	always_comb begin
		nxt_we = 1'b0; prv_we = 1'b0; lvl_we = 1'b0; head_we = 1'b0; tail_we = 1'b0;
		nxt_a = task_q; prv_a = task_q; lvl_a = task_q;
		head_a = best_q; tail_a = best_q;
		nxt_wd = task_q; prv_wd = task_q; lvl_wd = prio_q;
		head_wd = task_q; tail_wd = task_q;
		case (state_q)
			S_DEC: begin
				if (cmd_q == CMD_READY) begin
					tail_a = prio_q;
				end else begin
					head_a = best;
					tail_a = best;
				end
			end
			S_R2: begin
				tail_a  = prio_q;
				tail_we = 1'b1;
				lvl_we  = 1'b1;
				if (ready_q[prio_q]) begin
					nxt_a  = tail_rd;
					nxt_we = 1'b1;
					prv_wd = tail_rd;
					prv_we = 1'b1;
				end else begin
					head_a  = prio_q;
					head_we = 1'b1;
				end
			end
			S_U2: begin
				head_a = lvl_rd;
				tail_a = lvl_rd;
			end
			S_U3: begin
				head_a = lv_q;
				tail_a = lv_q;
				if (is_head && !is_tail) begin
					head_wd = n_q;
					head_we = 1'b1;
				end else if (is_tail && !is_head) begin
					tail_wd = p_q;
					tail_we = 1'b1;
				end else if (!is_head && !is_tail) begin
					nxt_a  = p_q;
					nxt_wd = n_q;
					nxt_we = 1'b1;
					prv_a  = n_q;
					prv_wd = p_q;
					prv_we = 1'b1;
				end
			end
			S_S2: begin
				nxt_a = head_rd;
			end
			S_S3: begin
				head_wd = nxt_rd;
				head_we = 1'b1;
				tail_wd = h_q;
				tail_we = 1'b1;
				nxt_a   = t_q;
				nxt_wd  = h_q;
				nxt_we  = 1'b1;
				prv_a   = h_q;
				prv_wd  = t_q;
				prv_we  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (nxt_we) begin
			nxt_mem[nxt_a] <= nxt_wd;
		end
		nxt_rd <= nxt_mem[nxt_a];
		if (prv_we) begin
			prv_mem[prv_a] <= prv_wd;
		end
		prv_rd <= prv_mem[prv_a];
		if (lvl_we) begin
			lvl_mem[lvl_a] <= lvl_wd;
		end
		lvl_rd <= lvl_mem[lvl_a];
		if (head_we) begin
			head_mem[head_a] <= head_wd;
		end
		head_rd <= head_mem[head_a];
		if (tail_we) begin
			tail_mem[tail_a] <= tail_wd;
		end
		tail_rd <= tail_mem[tail_a];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_q   <= cmd_t'(s_axis_tuser);
			task_q  <= s_axis_tdata[5:0];
			prio_q  <= s_axis_tdata[10:6];
			cur_q   <= s_axis_tdata[16:11];
			cprio_q <= s_axis_tdata[21:17];
			isr_q   <= s_axis_tdata[22];
			lock_q  <= s_axis_tdata[23];
		end
		if (state_q == S_DEC) begin
			best_q <= best;
		end
		if (state_q == S_U2) begin
			lv_q <= lvl_rd;
			n_q  <= nxt_rd;
			p_q  <= prv_rd;
		end
		if (state_q == S_S2) begin
			h_q <= head_rd;
			t_q <= tail_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ready_q    <= '0;
			queued_q   <= '0;
			res_next_q <= '0;
			res_stat_q <= STAT_OK;
			m_valid_q  <= 1'b0;
			m_next_q   <= '0;
			m_sw_q     <= 1'b0;
			m_stat_q   <= STAT_OK;
		end else begin
			// in S_FIN the load below decides the output register
			if (m_valid_q && m_axis_tready && state_q != S_FIN) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					res_next_q <= cur_q;
					res_stat_q <= STAT_OK;
					state_q    <= S_FIN;
					case (cmd_q)
						CMD_READY: begin
							if (task_ok && prio_ok && !queued_q[task_q]) begin
								state_q <= S_R2;
							end
						end
						CMD_UNREADY: begin
							if (task_ok && queued_q[task_q]) begin
								state_q <= S_U2;
							end
						end
						default: begin
							if (refuse) begin
								res_stat_q <= STAT_REFUSED;
							end else if (ready_q == '0) begin
								res_stat_q <= STAT_EMPTY;
							end else if (cmd_q == CMD_SCHED_N || best != cprio_q) begin
								state_q <= S_S2;
							end
						end
					endcase
				end
				S_R2: begin
					ready_q[prio_q]  <= 1'b1;
					queued_q[task_q] <= 1'b1;
					state_q          <= S_FIN;
				end
				S_U2: begin
					state_q <= S_U3;
				end
				S_U3: begin
					if (is_head && is_tail) begin
						ready_q[lv_q] <= 1'b0;
					end
					queued_q[task_q] <= 1'b0;
					state_q          <= S_FIN;
				end
				S_S2: begin
					res_next_q <= head_rd;
					// single task in the level: nothing to rotate
					state_q    <= (head_rd == tail_rd) ? S_FIN : S_S3;
				end
				S_S3: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_next_q  <= res_next_q;
						m_sw_q    <= res_next_q != cur_q;
						m_stat_q  <= res_stat_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_sw_q, m_next_q};
	assign m_axis_tuser  = m_stat_q;

	a_rotate_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_S3 |-> h_q != t_q)
		else $error("rotation entered with a single-task level");

	a_ready_sets_queued: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_R2 |=> queued_q[$past(task_q)] && ready_q[$past(prio_q)])
		else $error("ready command did not mark task and level");

	a_no_switch_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_stat_q != STAT_OK |-> !m_sw_q)
		else $error("switch requested on a failed schedule");

endmodule

`default_nettype wire

### hw/rtl/prqs_ffs.sv
`timescale 1ns / 1ps
`default_nettype none

module prqs_ffs (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire prqs_pkg::bitmap_t bits,
	output prqs_pkg::lvl_t        best
);
	import prqs_pkg::*;

	logic [NGRP-1:0]   grp_nz;
	logic [NGRP_W-1:0] gsel;
	logic [GRP-1:0]    slice;
	logic [GRP_W-1:0]  bsel;
	lvl_t              best_q;

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_nz[g] = |bits[g*GRP +: GRP];
		end
		gsel = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_nz[g]) begin
				gsel = NGRP_W'(g);
			end
		end
		slice = bits[gsel*GRP +: GRP];
		bsel = '0;
		for (int b = GRP - 1; b >= 0; b--) begin
			if (slice[b]) begin
				bsel = GRP_W'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else begin
			best_q <= {gsel, bsel};
		end
	end

	assign best = best_q;

endmodule

`default_nettype wire
